[hdl/eer_pkg.sv]
// Package: shared types, constants and elaboration-time CORDIC tables.
`timescale 1ns / 1ps
`default_nettype none
package eer_pkg;

  localparam int ANGLE_BITS = 32;
  localparam int CORDIC_STAGES_DEF = 30;
  localparam int FRAC = 30;
  localparam int ZW = 64;
  localparam int CW = 34;
  localparam int AW = 36;
  localparam int OBL_BITS = 31;
  localparam int SH = 62 - ANGLE_BITS;
  localparam int SQ_STEPS = FRAC + 1;
  localparam int NW = 2 * FRAC + 1;
  localparam int RW = 2 * FRAC + 2;

  localparam logic signed [ZW-1:0] HALF_TURN = 64'sd1 <<< 61;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 64'sd1 <<< 60;
  localparam logic signed [ZW-1:0] ONE = 64'sd1 <<< FRAC;
  localparam logic [OBL_BITS-1:0] OBL_RESET = 31'd279636000;
  localparam logic REG_OBLIQUITY = 1'b0;
  localparam logic [63:0] THIRD_Q61 = (64'd1 << 61) / 64'd3;

  typedef struct packed {
    logic                         func;
    logic signed [ANGLE_BITS-1:0] angle_lon;
    logic signed [ANGLE_BITS-1:0] angle_lat;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] out_lon;
    logic signed [ANGLE_BITS-1:0] out_lat;
    logic                         clipped;
  } out_item_t;

  // unsigned 64-bit quotient by shift and subtract; d is never zero here
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan power series, Q61; sq = 1/x^2, zero means a single term
  function automatic logic [63:0] atan_series(logic [63:0] x, logic [63:0] sq);
    logic [63:0] sum;
    logic [63:0] p;
    logic [63:0] k;
    logic done;
    sum = 64'd0;
    p = x;
    k = 64'd0;
    done = 1'b0;
    for (int n = 0; n < 64; n++) begin
      if (!done) begin
        if (k[0]) sum = sum - udiv64(p, 2 * k + 64'd1);
        else sum = sum + udiv64(p, 2 * k + 64'd1);
        if (sq == 64'd0) begin
          done = 1'b1;
        end else begin
          p = udiv64(p, sq);
          k = k + 64'd1;
          if (p == 64'd0) done = 1'b1;
        end
      end
    end
    return sum;
  endfunction

  // round(atan(2^-i) * 2^61 / pi)
  function automatic logic [63:0] atan_entry(int i);
    logic [63:0] pi_q;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] sq;
    pi_q = 64'd4 * (atan_series(64'd1 << 60, 64'd4) +
                    atan_series(THIRD_Q61, 64'd9));
    if (i == 0) return 64'd1 << 59;
    sq = (2 * i < 64) ? (64'd1 << (2 * i)) : 64'd0;
    r = atan_series(64'd1 << (61 - i), sq);
    q = 64'd0;
    for (int b = 0; b < 61; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= pi_q) begin
        r = r - pi_q;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= pi_q) q = q + 64'd1;
    return q;
  endfunction

  // inverse CORDIC gain, Q30
  function automatic logic [CW-1:0] kinv_calc(int stages);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic [63:0] ux;
    x = 64'sd1 <<< FRAC;
    y = 64'sd0;
    z = 64'sd0;
    for (int i = 0; i < stages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - signed'(atan_entry(i));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + signed'(atan_entry(i));
      end
    end
    ux = unsigned'(x);
    return CW'(udiv64((64'd1 << 60) + (ux >> 1), ux));
  endfunction

endpackage
`default_nettype wire

[hdl/eer_sincos.sv]
// Pipelined CORDIC rotation: sine and cosine of an inner angle.
`timescale 1ns / 1ps
`default_nettype none
module eer_sincos import eer_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic signed [ZW-1:0] ang,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam logic signed [CW-1:0] KINV = signed'(kinv_calc(STAGES));

  logic signed [CW-1:0] x_r [STAGES+1];
  logic signed [CW-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0] z_r [STAGES+1];
  logic                 neg_r [STAGES+1];
  logic signed [CW-1:0] cos_r;
  logic signed [CW-1:0] sin_r;

  always_ff @(posedge clk) begin
    x_r[0] <= KINV;
    y_r[0] <= '0;
    if (ang > QUARTER_TURN) begin
      z_r[0]   <= ang - HALF_TURN;
      neg_r[0] <= 1'b1;
    end else if (ang < -QUARTER_TURN) begin
      z_r[0]   <= ang + HALF_TURN;
      neg_r[0] <= 1'b1;
    end else begin
      z_r[0]   <= ang;
      neg_r[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_I = signed'(atan_entry(i));
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_I;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= neg_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
    sin_r <= neg_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

[hdl/eer_isqrt.sv]
// Pipelined integer square root, two radicand bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module eer_isqrt import eer_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] rad,
  output logic [FRAC:0] root
);

  logic [RW-1:0] n_r   [SQ_STEPS];
  logic [RW-1:0] res_r [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * FRAC - 2 * j);
    logic [RW-1:0] n_in;
    logic [RW-1:0] res_in;
    if (j == 0) begin : g_first
      assign n_in   = RW'(rad);
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_r[j-1];
      assign res_in = res_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (n_in >= res_in + BIT) begin
        n_r[j]   <= n_in - (res_in + BIT);
        res_r[j] <= (res_in >> 1) + BIT;
      end else begin
        n_r[j]   <= n_in;
        res_r[j] <= res_in >> 1;
      end
    end
  end

  assign root = res_r[SQ_STEPS-1][FRAC:0];

endmodule
`default_nettype wire

[hdl/eer_atan2.sv]
// Pipelined CORDIC vectoring: atan2(y, x) as an inner angle.
`timescale 1ns / 1ps
`default_nettype none
module eer_atan2 import eer_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic signed [ZW-1:0] ang_o
);

  logic signed [AW-1:0] x_r [STAGES+1];
  logic signed [AW-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0] z_r [STAGES+1];
  logic                 zero_r [STAGES+1];

  always_ff @(posedge clk) begin
    zero_r[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      z_r[0] <= (y_i >= 0) ? HALF_TURN : -HALF_TURN;
      x_r[0] <= -AW'(x_i);
      y_r[0] <= -AW'(y_i);
    end else begin
      z_r[0] <= '0;
      x_r[0] <= AW'(x_i);
      y_r[0] <= AW'(y_i);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_I = signed'(atan_entry(i));
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_I;
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_I;
      end
    end
  end

  assign ang_o = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule
`default_nettype wire

[hdl/ecliptic_equatorial_rotate.sv]
// Top level: ecliptic/equatorial rotation pipeline with obliquity register.
//
// channel   ports                                 transaction
// input     start, busy, in_data                  start && !busy
// result    out_valid, out_data                   out_valid (one cycle)
// config    psel penable pwrite paddr pwdata ...  psel && penable && pwrite
//
// One position enters per cycle; busy is always low.
// The pipeline holds two CORDIC chains (rotation, then vectoring), a 31-step
// square root and five multiply/clip stages.
// rst_n clears the valid line and loads the default obliquity.
`timescale 1ns / 1ps
`default_nettype none
module ecliptic_equatorial_rotate import eer_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LAT = 2 * CORDIC_STAGES + 40;
  localparam int CLIP_DLY = SQ_STEPS + CORDIC_STAGES + 1;

  logic [OBL_BITS-1:0] obl_r;
  logic [LAT-1:0]      v_r;

  logic signed [ZW-1:0] lon_in, lat_in, eps_in;
  logic signed [CW-1:0] cl, sl, cb, sb, ce, se;

  logic signed [CW-1:0] x1_r, y01_r, sb1_r, ce1_r, se1_r;
  logic signed [2*CW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [CW-1:0] x2_r;
  logic signed [2*CW:0] dy, dz;
  logic signed [CW:0]   zpre;
  logic signed [CW-1:0] yr3_r, x3_r, yr4_r, x4_r, yr5_r, x5_r;
  logic signed [FRAC+1:0] zr3_r, zr4_r, zr5_r;
  logic clip3_r, clip4_r, clip5_r;
  logic [NW-1:0] sq4_r, n5_r;
  logic [FRAC:0] root;

  logic signed [CW-1:0]   dyr_r [SQ_STEPS];
  logic signed [CW-1:0]   dx_r  [SQ_STEPS];
  logic signed [FRAC+1:0] dzr_r [SQ_STEPS];
  logic                   dclip_r [CLIP_DLY];

  logic signed [ZW-1:0] lon_z, lat_z, lon_rnd, lat_rnd;
  out_item_t            out_r;

  logic wr_en;

  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_OBLIQUITY);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OBLIQUITY) ? 32'(obl_r) : 32'd0;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obl_r <= OBL_RESET;
      v_r   <= '0;
    end else begin
      if (wr_en) obl_r <= pwdata[OBL_BITS-1:0];
      v_r <= {v_r[LAT-2:0], start && !busy};
    end
  end

  assign lon_in = ZW'(in_data.angle_lon) <<< SH;
  assign lat_in = ZW'(in_data.angle_lat) <<< SH;
  assign eps_in = in_data.func ? -(signed'(ZW'(obl_r)) <<< FRAC)
                               : (signed'(ZW'(obl_r)) <<< FRAC);

  eer_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lon (
    .clk(clk), .ang(lon_in), .cos_o(cl), .sin_o(sl));
  eer_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat (
    .clk(clk), .ang(lat_in), .cos_o(cb), .sin_o(sb));
  eer_sincos #(.STAGES(CORDIC_STAGES)) u_sc_eps (
    .clk(clk), .ang(eps_in), .cos_o(ce), .sin_o(se));

  assign dy   = (2*CW+1)'(pa_r) - (2*CW+1)'(pb_r);
  assign dz   = (2*CW+1)'(pc_r) + (2*CW+1)'(pd_r);
  assign zpre = dz[FRAC+CW:FRAC];

  always_ff @(posedge clk) begin
    // x and y0 of the unit vector
    x1_r  <= CW'((2*CW)'(cb) * (2*CW)'(cl) >>> FRAC);
    y01_r <= CW'((2*CW)'(cb) * (2*CW)'(sl) >>> FRAC);
    sb1_r <= sb;
    ce1_r <= ce;
    se1_r <= se;
    // rotation products
    pa_r <= (2*CW)'(y01_r) * (2*CW)'(ce1_r);
    pb_r <= (2*CW)'(sb1_r) * (2*CW)'(se1_r);
    pc_r <= (2*CW)'(y01_r) * (2*CW)'(se1_r);
    pd_r <= (2*CW)'(sb1_r) * (2*CW)'(ce1_r);
    x2_r <= x1_r;
    // sums and asin clip
    yr3_r <= dy[FRAC+CW-1:FRAC];
    x3_r  <= x2_r;
    if (zpre > (CW+1)'(ONE)) begin
      zr3_r   <= (FRAC+2)'(ONE);
      clip3_r <= 1'b1;
    end else if (zpre < -(CW+1)'(ONE)) begin
      zr3_r   <= -(FRAC+2)'(ONE);
      clip3_r <= 1'b1;
    end else begin
      zr3_r   <= zpre[FRAC+1:0];
      clip3_r <= 1'b0;
    end
    // square
    sq4_r   <= NW'(ZW'(zr3_r) * ZW'(zr3_r));
    yr4_r   <= yr3_r;
    x4_r    <= x3_r;
    zr4_r   <= zr3_r;
    clip4_r <= clip3_r;
    // 1 - z^2
    n5_r    <= (NW'(1) << (2 * FRAC)) - sq4_r;
    yr5_r   <= yr4_r;
    x5_r    <= x4_r;
    zr5_r   <= zr4_r;
    clip5_r <= clip4_r;
  end

  eer_isqrt u_isqrt (.clk(clk), .rad(n5_r), .root(root));

  always_ff @(posedge clk) begin
    dyr_r[0]   <= yr5_r;
    dx_r[0]    <= x5_r;
    dzr_r[0]   <= zr5_r;
    dclip_r[0] <= clip5_r;
    for (int k = 1; k < SQ_STEPS; k++) begin
      dyr_r[k] <= dyr_r[k-1];
      dx_r[k]  <= dx_r[k-1];
      dzr_r[k] <= dzr_r[k-1];
    end
    for (int k = 1; k < CLIP_DLY; k++) begin
      dclip_r[k] <= dclip_r[k-1];
    end
  end

  eer_atan2 #(.STAGES(CORDIC_STAGES)) u_at_lon (
    .clk(clk), .y_i(dyr_r[SQ_STEPS-1]), .x_i(dx_r[SQ_STEPS-1]), .ang_o(lon_z));
  eer_atan2 #(.STAGES(CORDIC_STAGES)) u_at_lat (
    .clk(clk), .y_i(CW'(dzr_r[SQ_STEPS-1])), .x_i(CW'(root)), .ang_o(lat_z));

  assign lon_rnd = lon_z + (64'sd1 <<< (SH - 1));
  assign lat_rnd = lat_z + (64'sd1 <<< (SH - 1));

  always_ff @(posedge clk) begin
    out_r.out_lon <= lon_rnd[SH+ANGLE_BITS-1:SH];
    out_r.out_lat <= lat_rnd[SH+ANGLE_BITS-1:SH];
    out_r.clipped <= dclip_r[CLIP_DLY-1];
  end

  assign out_valid = v_r[LAT-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire
